// ===== design/prd_pkg.sv =====
// shared constants, types and saturation helpers for the pulse rate detector
// no dependencies; imported by pulse_rate_detector_unit

package prd_pkg;

  // field and state widths
  localparam int SAMPLE_BITS = 16;
  localparam int PERIOD_BITS = 12;
  localparam int CFG_BITS    = 16;
  localparam int RATE_BITS   = 16;
  localparam int DC_BITS     = SAMPLE_BITS + 4;
  localparam int DCX_BITS    = DC_BITS + 2;
  localparam int FILT_BITS   = SAMPLE_BITS + 2;

  // low-pass coefficients in q0.16, processed one bit per cycle
  localparam int COEF_BITS = 16;
  localparam int LP_SHIFT  = 16;
  localparam logic [COEF_BITS-1:0] LP_IN_COEF = COEF_BITS'(16072);
  localparam logic [COEF_BITS-1:0] LP_FB_COEF = COEF_BITS'(33392);

  // accumulator holds coef * d + coef * y with headroom
  localparam int ACC_BITS = FILT_BITS + COEF_BITS + 2;

  // compare width for previous - drop threshold
  localparam int CMP_BITS = ((FILT_BITS > CFG_BITS) ? FILT_BITS : CFG_BITS) + 2;

  // serial step counter covers both the multiply and the divide
  localparam int MAX_STEPS = (COEF_BITS > RATE_BITS) ? COEF_BITS : RATE_BITS;
  localparam int STEP_BITS = $clog2(MAX_STEPS);

  // register reset values
  localparam logic [CFG_BITS-1:0] DROP_THRESHOLD_RST = CFG_BITS'(20);
  localparam logic [CFG_BITS-1:0] RATE_CONSTANT_RST  = CFG_BITS'(1200);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DROP_THRESHOLD = 1'b0,
    REG_RATE_CONSTANT  = 1'b1
  } cfg_reg_e;

  // stream payload widths
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((RATE_BITS + FILT_BITS + 7) / 8) * 8;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  // saturate a widened dc sum to the dc state range
  function automatic logic signed [DC_BITS-1:0] sat_dc(input logic signed [DCX_BITS-1:0] v);
    logic signed [DCX_BITS-1:0] hi;
    logic signed [DCX_BITS-1:0] lo;
    hi = DCX_BITS'({1'b0, {(DC_BITS-1){1'b1}}});
    lo = -hi - DCX_BITS'(1);
    if (v > hi) begin
      return DC_BITS'(hi);
    end else if (v < lo) begin
      return DC_BITS'(lo);
    end
    return DC_BITS'(v);
  endfunction

  // saturate a wide signed value to the filter range
  function automatic logic signed [FILT_BITS-1:0] sat_filt(input logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    hi = ACC_BITS'({1'b0, {(FILT_BITS-1){1'b1}}});
    lo = -hi - ACC_BITS'(1);
    if (v > hi) begin
      return FILT_BITS'(hi);
    end else if (v < lo) begin
      return FILT_BITS'(lo);
    end
    return FILT_BITS'(v);
  endfunction

endpackage

// ===== design/pulse_rate_detector_unit.sv =====
// pulse rate detector: dc removal, bit-serial low-pass, beat logic, serial divider
// depends on prd_pkg
//
// steps per item: one low-pass step per coefficient bit, one beat step, one divide step
// per rate bit and one output load; the divide is skipped while no beat period is latched.
// one item in flight, so a new item is taken only once the previous one has loaded the
// output register. the output register lets the next item start while a result
// waits; a second result stalls in the output state until the receiver takes the first.
// reset (rst_ni low, asynchronous) clears filter state, beat state and counters
// and loads drop threshold 20 and rate constant 1200.

module pulse_rate_detector_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [prd_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [prd_pkg::CFG_BITS-1:0]        cfg_data_i,
  // sample stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [prd_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,  // sample
  // result stream out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [prd_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,  // rate, filtered, zero pad
  output logic                                m_axis_tuser   // rate_valid
);
  import prd_pkg::*;

  // configuration registers
  logic [CFG_BITS-1:0] drop_thr_q;
  logic [CFG_BITS-1:0] rate_const_q;

  // control
  state_e               state_q, state_d;
  logic [STEP_BITS-1:0] step_q, step_d;

  // filter and beat state
  logic signed [DC_BITS-1:0]   w_q, w_d;
  logic signed [FILT_BITS-1:0] d_q, d_d;
  logic signed [FILT_BITS-1:0] y_q, y_d;
  logic signed [ACC_BITS-1:0]  acc_q, acc_d;
  logic                        armed_q, armed_d;
  logic [PERIOD_BITS-1:0]      cnt_q, cnt_d;
  logic [PERIOD_BITS-1:0]      period_q, period_d;

  // divider
  logic [PERIOD_BITS-1:0] rem_q, rem_d;
  logic [RATE_BITS-1:0]   quo_q, quo_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [RATE_BITS-1:0]        out_rate_q, out_rate_d;
  logic                        out_rv_q, out_rv_d;
  logic signed [FILT_BITS-1:0] out_filt_q, out_filt_d;

  // dc removal datapath
  logic signed [DCX_BITS-1:0] w_ext;
  logic signed [DCX_BITS-1:0] w_x3;
  logic signed [DCX_BITS-1:0] w_x3_adj;
  logic signed [DCX_BITS-1:0] w_sum;
  logic signed [DC_BITS-1:0]  w_new;
  logic signed [ACC_BITS-1:0] dw_ext;

  // low-pass serial step
  logic signed [ACC_BITS-1:0] term_in;
  logic signed [ACC_BITS-1:0] term_fb;
  logic signed [ACC_BITS-1:0] acc_adj;
  logic signed [ACC_BITS-1:0] y_wide;
  logic signed [FILT_BITS-1:0] y_new;

  // beat logic
  logic signed [CMP_BITS-1:0] drop_lvl;
  logic signed [CMP_BITS-1:0] y_new_ext;
  logic signed [CMP_BITS-1:0] y_prev_ext;
  logic                       rise;
  logic                       fall;
  logic                       armed_mid;
  logic [PERIOD_BITS-1:0]     cnt_mid;
  logic [PERIOD_BITS-1:0]     period_new;

  // divider step
  logic [PERIOD_BITS:0]   rem_sh;
  logic [PERIOD_BITS:0]   rem_diff;
  logic                   rem_ge;

  logic in_fire;
  logic out_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // dc removal: w = x + trunc(0.75 * w_prev), d = w - w_prev
  always_comb begin
    w_ext    = DCX_BITS'(w_q);
    w_x3     = (w_ext <<< 1) + w_ext;
    w_x3_adj = w_x3 + (w_x3[DCX_BITS-1] ? DCX_BITS'(3) : DCX_BITS'(0));
    w_sum    = $signed(DCX_BITS'({1'b0, s_axis_tdata[SAMPLE_BITS-1:0]})) + (w_x3_adj >>> 2);
    w_new    = sat_dc(w_sum);
    dw_ext   = ACC_BITS'(w_new) - ACC_BITS'(w_q);
  end

  // low-pass: one coefficient bit per cycle, msb first
  always_comb begin
    term_in = LP_IN_COEF[step_q] ? ACC_BITS'(d_q) : '0;
    term_fb = LP_FB_COEF[step_q] ? ACC_BITS'(y_q) : '0;
    acc_adj = acc_q + (acc_q[ACC_BITS-1] ? ACC_BITS'((1 << LP_SHIFT) - 1) : ACC_BITS'(0));
    y_wide  = acc_adj >>> LP_SHIFT;
    y_new   = sat_filt(y_wide);
  end

  // beat arm, beat end and saturating sample count
  always_comb begin
    y_new_ext  = CMP_BITS'(y_new);
    y_prev_ext = CMP_BITS'(y_q);
    drop_lvl   = y_prev_ext - CMP_BITS'({1'b0, drop_thr_q});
    rise       = y_new_ext > y_prev_ext;
    armed_mid  = armed_q || rise;
    fall       = armed_mid && (y_new_ext <= drop_lvl);
    cnt_mid    = fall ? '0 : cnt_q;
    period_new = fall ? cnt_q : period_q;
  end

  // restoring divide step
  always_comb begin
    rem_sh   = {rem_q, quo_q[RATE_BITS-1]};
    rem_diff = rem_sh - {1'b0, period_q};
    rem_ge   = rem_sh >= {1'b0, period_q};
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    w_d         = w_q;
    d_d         = d_q;
    y_d         = y_q;
    acc_d       = acc_q;
    armed_d     = armed_q;
    cnt_d       = cnt_q;
    period_d    = period_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_rate_d  = out_rate_q;
    out_rv_d    = out_rv_q;
    out_filt_d  = out_filt_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          w_d     = w_new;
          d_d     = sat_filt(dw_ext);
          acc_d   = '0;
          step_d  = STEP_BITS'(COEF_BITS - 1);
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        acc_d = (acc_q <<< 1) + term_in + term_fb;
        if (step_q == '0) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q - STEP_BITS'(1);
        end
      end
      ST_FIN: begin
        y_d      = y_new;
        armed_d  = armed_mid && !fall;
        cnt_d    = (cnt_mid != '1) ? cnt_mid + PERIOD_BITS'(1) : cnt_mid;
        period_d = period_new;
        rem_d    = '0;
        quo_d    = rate_const_q;
        step_d   = STEP_BITS'(RATE_BITS - 1);
        state_d  = (period_new != '0) ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        rem_d = rem_ge ? rem_diff[PERIOD_BITS-1:0] : rem_sh[PERIOD_BITS-1:0];
        quo_d = {quo_q[RATE_BITS-2:0], rem_ge};
        if (step_q == '0) begin
          state_d = ST_OUT;
        end else begin
          step_d = step_q - STEP_BITS'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rv_d    = period_q != '0;
          out_rate_d  = (period_q != '0) ? quo_q : '0;
          out_filt_d  = y_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      w_q         <= '0;
      y_q         <= '0;
      armed_q     <= 1'b0;
      cnt_q       <= '0;
      period_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      w_q         <= w_d;
      y_q         <= y_d;
      armed_q     <= armed_d;
      cnt_q       <= cnt_d;
      period_q    <= period_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    d_q        <= d_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_rate_q <= out_rate_d;
    out_rv_q   <= out_rv_d;
    out_filt_q <= out_filt_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_thr_q   <= DROP_THRESHOLD_RST;
      rate_const_q <= RATE_CONSTANT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DROP_THRESHOLD: drop_thr_q   <= cfg_data_i;
        REG_RATE_CONSTANT:  rate_const_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // stream ports
  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_rv_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS - RATE_BITS - FILT_BITS){1'b0}},
                          out_filt_q, out_rate_q};

  // an accepted request always starts the low-pass sweep
  a_start_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_MAC)
    else $error("low-pass sweep did not start after input request");

  // divider remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < period_q)
    else $error("divider remainder out of range");

  // a result without a period carries a zero rate
  a_zero_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[RATE_BITS-1:0] == '0)
    else $error("nonzero rate without a beat period");

  // every finished item leaves a nonzero sample count
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> cnt_q != '0)
    else $error("sample count zero after an item");

endmodule
